// ===== rtl/c64au_pkg.sv =====
// shared types and constants for the 64-bit count arithmetic unit
// no dependencies; imported by count64_arith_unit
`default_nettype none

package c64au_pkg;

    localparam int OpW     = 64;
    localparam int ScW     = 32;
    localparam int DivStps = OpW;

    localparam logic [ScW-1:0] ScaleUs = 32'd1000;
    localparam logic [ScW-1:0] ScaleMs = 32'd1000000;
    localparam logic [ScW-1:0] ScaleS  = 32'd1000000000;
    localparam logic [ScW-1:0] Sat32   = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_CMP     = 4'd2,
        FN_ZERO    = 4'd3,
        FN_MUL     = 4'd4,
        FN_DIV     = 4'd5,
        FN_FROM_US = 4'd6,
        FN_FROM_MS = 4'd7,
        FN_FROM_S  = 4'd8,
        FN_TO_US   = 4'd9,
        FN_TO_MS   = 4'd10,
        FN_TO_S    = 4'd11
    } t_func;

    localparam logic [1:0] OrdLess = 2'b11;
    localparam logic [1:0] OrdEq   = 2'b00;
    localparam logic [1:0] OrdGrt  = 2'b01;

    // one pipeline slot
    typedef struct packed {
        logic           vld;
        t_func          fn;
        logic [OpW-1:0] val;  // add/sub result, then product
        logic [OpW-1:0] wrk;  // multiplicand / dividend, becomes quotient
        logic [ScW-1:0] dv;   // multiplier / divisor
        logic [OpW-1:0] ph;   // upper partial product
        logic [ScW-1:0] rem;  // partial remainder
        logic [1:0]     ord;
        logic           zer;
    } t_stage;

endpackage

`default_nettype wire

// ===== rtl/count64_arith_unit.sv =====
// unsigned 64-bit count arithmetic unit, fully pipelined
// depends on c64au_pkg
//
// Usage: a request carries the function code on i_s_axis_tuser and operand_a,
// operand_b and scalar on i_s_axis_tdata. Each request gives exactly one result
// on o_m_axis_tdata (value, remainder, order, is_zero from bit 0 up).
// A request passes the input stage, which loads at the accepting edge, then a
// 32x32 partial product stage, a product sum stage, 64 restoring divide stages
// of one quotient bit each, and the output register behind o_m_axis_tvalid.
// Throughput is one request per cycle while the receiver does not stall; the
// 64-step divide pipeline sets the latency. Conversions to a unit reuse the
// divider with a constant divisor and conversions from a unit reuse the
// multiplier with a constant factor.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_s_axis_tready drops; nothing is lost or repeated. Requests behind empty
// slots keep moving only while the output register is free or taken.
// Reset (synchronous, active low) clears all valid bits; no other state.
`default_nettype none

module count64_arith_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // operand_a [63:0], operand_b [127:64], scalar [159:128]
    input  wire logic [159:0] i_s_axis_tdata,
    // func [3:0]
    input  wire logic [3:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // value [63:0], remainder [95:64], order [97:96], is_zero [98], zero pad
    output logic [103:0]      o_m_axis_tdata
);
    import c64au_pkg::*;

    localparam int NStg = DivStps + 3;

    t_stage r_st [NStg];
    t_stage n_st [NStg];

    logic           r_out_vld;
    logic [OpW-1:0] r_out_val;
    logic [ScW-1:0] r_out_rem;
    logic [1:0]     r_out_ord;
    logic           r_out_zer;
    logic [OpW-1:0] n_out_val;
    logic [ScW-1:0] n_out_rem;

    logic           en;
    logic [OpW-1:0] in_a;
    logic [OpW-1:0] in_b;
    logic [ScW-1:0] in_s;
    t_func          in_fn;

    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign in_a            = i_s_axis_tdata[63:0];
    assign in_b            = i_s_axis_tdata[127:64];
    assign in_s            = i_s_axis_tdata[159:128];
    assign in_fn           = t_func'(i_s_axis_tuser);

    // input decode: simple ops resolve here, others pick operands
    always_comb begin
        n_st[0]     = '0;
        n_st[0].vld = i_s_axis_tvalid;
        n_st[0].fn  = in_fn;
        n_st[0].wrk = in_a;
        n_st[0].dv  = in_s;
        case (in_fn)
            FN_ADD:     n_st[0].val = in_a + in_b;
            FN_SUB:     n_st[0].val = in_a - in_b;
            FN_CMP: begin
                if (in_a == in_b) begin
                    n_st[0].ord = OrdEq;
                end else if (in_a < in_b) begin
                    n_st[0].ord = OrdLess;
                end else begin
                    n_st[0].ord = OrdGrt;
                end
            end
            FN_ZERO:    n_st[0].zer = (in_a == '0);
            FN_FROM_US: begin
                n_st[0].wrk = {{(OpW-ScW){1'b0}}, in_s};
                n_st[0].dv  = ScaleUs;
            end
            FN_FROM_MS: begin
                n_st[0].wrk = {{(OpW-ScW){1'b0}}, in_s};
                n_st[0].dv  = ScaleMs;
            end
            FN_FROM_S: begin
                n_st[0].wrk = {{(OpW-ScW){1'b0}}, in_s};
                n_st[0].dv  = ScaleS;
            end
            // repeated division by 1000 equals one division by the product
            FN_TO_US:   n_st[0].dv = ScaleUs;
            FN_TO_MS:   n_st[0].dv = ScaleMs;
            FN_TO_S:    n_st[0].dv = ScaleS;
            default:    ;
        endcase
    end

    // partial products
    always_comb begin
        n_st[1] = r_st[0];
        case (r_st[0].fn)
            FN_MUL, FN_FROM_US, FN_FROM_MS, FN_FROM_S: begin
                n_st[1].val = r_st[0].wrk[ScW-1:0] * r_st[0].dv;
                n_st[1].ph  = r_st[0].wrk[OpW-1:ScW] * r_st[0].dv;
            end
            default: ;
        endcase
    end

    // product sum modulo 2^64
    always_comb begin
        n_st[2] = r_st[1];
        case (r_st[1].fn)
            FN_MUL, FN_FROM_US, FN_FROM_MS, FN_FROM_S: begin
                n_st[2].val = r_st[1].val + {r_st[1].ph[ScW-1:0], {ScW{1'b0}}};
            end
            default: ;
        endcase
        n_st[2].rem = '0;
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < DivStps; k++) begin : g_div
        logic [ScW:0] trial;
        logic         qbit;
        assign trial = {r_st[k+2].rem, r_st[k+2].wrk[OpW-1]};
        assign qbit  = (trial >= {1'b0, r_st[k+2].dv});
        always_comb begin
            n_st[k+3]     = r_st[k+2];
            n_st[k+3].wrk = {r_st[k+2].wrk[OpW-2:0], qbit};
            if (qbit) begin
                n_st[k+3].rem = ScW'(trial - {1'b0, r_st[k+2].dv});
            end else begin
                n_st[k+3].rem = trial[ScW-1:0];
            end
        end
    end

    // result select
    always_comb begin
        n_out_val = r_st[NStg-1].val;
        n_out_rem = '0;
        case (r_st[NStg-1].fn)
            FN_DIV: begin
                // zero divisor leaves an all-ones quotient by itself
                n_out_val = r_st[NStg-1].wrk;
                if (r_st[NStg-1].dv != '0) begin
                    n_out_rem = r_st[NStg-1].rem;
                end
            end
            FN_TO_US, FN_TO_MS, FN_TO_S: begin
                if (r_st[NStg-1].wrk[OpW-1:ScW] != '0) begin
                    n_out_val = {{(OpW-ScW){1'b0}}, Sat32};
                end else begin
                    n_out_val = {{(OpW-ScW){1'b0}}, r_st[NStg-1].wrk[ScW-1:0]};
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_FROM_US, FN_FROM_MS, FN_FROM_S: ;
            default: n_out_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NStg; k++) begin
                r_st[k].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < NStg; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out_vld <= r_st[NStg-1].vld;
            r_out_val <= n_out_val;
            r_out_rem <= n_out_rem;
            r_out_ord <= r_st[NStg-1].ord;
            r_out_zer <= r_st[NStg-1].zer;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out_zer, r_out_ord, r_out_rem, r_out_val};

endmodule

`default_nettype wire

// ===== verif/count64_arith_unit_chk.sv =====
// result checker for the 64-bit count arithmetic unit: predicts each request and compares
// depends on c64au_pkg and on the stream handshakes of count64_arith_unit
`timescale 1ns / 100ps

module count64_arith_unit_chk (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_req_valid,
    input  wire logic         i_req_ready,
    // operand_a [63:0], operand_b [127:64], scalar [159:128]
    input  wire logic [159:0] i_req_data,
    // func [3:0]
    input  wire logic [3:0]   i_req_user,
    input  wire logic         i_res_valid,
    input  wire logic         i_res_ready,
    // value [63:0], remainder [95:64], order [97:96], is_zero [98], zero pad
    input  wire logic [103:0] i_res_data,
    output int                o_fail_cnt,
    output int                o_pending
);
    import c64au_pkg::*;

    logic [103:0] exp_results[$];

    function automatic logic [63:0] ns_to_unit(logic [63:0] ns, int passes);
        for (int k = 0; k < passes; k++) ns = ns / 64'd1000;
        return (ns[63:32] != 0) ? 64'h0000_0000_FFFF_FFFF : ns;
    endfunction

    function automatic logic [103:0] count_result(logic [3:0] fn, logic [159:0] d);
        logic [63:0] a, b, v;
        logic [31:0] s, r;
        logic [1:0]  o;
        logic        z;
        a = d[63:0];
        b = d[127:64];
        s = d[159:128];
        v = '0;
        r = '0;
        o = OrdEq;
        z = 1'b0;
        case (fn)
            FN_ADD:     v = a + b;
            FN_SUB:     v = a - b;
            FN_CMP:     o = (a == b) ? OrdEq : ((a < b) ? OrdLess : OrdGrt);
            FN_ZERO:    z = (a == 0);
            FN_MUL:     v = a * {32'd0, s};
            FN_DIV: begin
                if (s == 0) begin
                    v = '1;
                end else begin
                    v = a / {32'd0, s};
                    r = 32'(a % {32'd0, s});
                end
            end
            FN_FROM_US: v = {32'd0, s} * 64'd1000;
            FN_FROM_MS: v = {32'd0, s} * 64'd1000000;
            FN_FROM_S:  v = {32'd0, s} * 64'd1000000000;
            FN_TO_US:   v = ns_to_unit(a, 1);
            FN_TO_MS:   v = ns_to_unit(a, 2);
            FN_TO_S:    v = ns_to_unit(a, 3);
            default: ;
        endcase
        return {5'd0, z, o, r, v};
    endfunction

    assign o_pending = exp_results.size();

    always @(posedge i_clk) begin
        logic [103:0] want;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                exp_results.push_back(count_result(i_req_user, i_req_data));
            if (i_res_valid && i_res_ready) begin
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_res_data);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = exp_results.pop_front();
                    if (want !== i_res_data) begin
                        $display("%0t: mismatch value exp %h got %h rem exp %h got %h",
                                 $time, want[63:0], i_res_data[63:0],
                                 want[95:64], i_res_data[95:64]);
                        $display("%0t:   order exp %b got %b zero exp %b got %b pad %h",
                                 $time, want[97:96], i_res_data[97:96], want[98],
                                 i_res_data[98], i_res_data[103:99]);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/count64_arith_unit_tb.sv =====
// top of the count64_arith_unit testbench: clock, reset, request stimulus and verdict
// depends on c64au_pkg, count64_arith_unit and count64_arith_unit_chk
`timescale 1ns / 100ps

module count64_arith_unit_tb;
    import c64au_pkg::*;

    localparam int Latency = 68;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [159:0] s_data = '0;
    logic [3:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [103:0] m_data;
    int           fail_cnt;
    int           pending;
    int           n_req = 0;
    bit           recv_on = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    count64_arith_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    count64_arith_unit_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_valid),
        .i_req_ready (s_ready),
        .i_req_data  (s_data),
        .i_req_user  (s_user),
        .i_res_valid (m_valid),
        .i_res_ready (m_ready),
        .i_res_data  (m_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = {32'd0, $urandom};
            3: v = 64'(1) << $urandom_range(0, 63);
            4: v = 64'($urandom_range(0, 5000)) * 64'd1000000000;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = $urandom_range(1, 15);
            3: v = 32'(1) << $urandom_range(0, 31);
            default: ;
        endcase
        return v;
    endfunction

    // one request, with a random gap before it when gaps is set (stream stays valid across back-to-back)
    task automatic send_req(logic [3:0] fn, logic [63:0] a, logic [63:0] b, logic [31:0] s,
                            bit gaps);
        int gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= fn;
        s_data  <= {s, b, a};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        n_req++;
    endtask

    // receiver: per result a drawn stall, with long stretches of full speed
    initial begin
        int stall;
        @(posedge i_clk);
        while (!recv_on) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (!m_valid) @(posedge i_clk);
        end
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [63:0] a;
        int wait_cnt;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        recv_on = 1'b1;
        @(posedge i_clk);

        // directed: field extremes, each function, special cases
        send_req(FN_ADD, '1, 64'd1, 32'd0, 0);
        send_req(FN_ADD, '0, '0, '1, 0);
        send_req(FN_SUB, '0, 64'd1, 32'd0, 0);
        send_req(FN_SUB, '1, '1, 32'd0, 0);
        send_req(FN_CMP, 64'd5, 64'd6, 32'd0, 0);
        send_req(FN_CMP, '1, '1, 32'd0, 0);
        send_req(FN_CMP, '1, '0, 32'd0, 0);
        send_req(FN_ZERO, '0, '1, '1, 0);
        send_req(FN_ZERO, 64'd1, '0, 32'd0, 0);
        send_req(FN_MUL, '1, '0, '1, 0);
        send_req(FN_MUL, 64'h1_0000_0000, '0, 32'h1_0000, 0);
        send_req(FN_DIV, '1, '0, 32'd0, 0);
        send_req(FN_DIV, '1, '0, '1, 0);
        send_req(FN_DIV, '1, '0, 32'd1, 0);
        send_req(FN_DIV, 64'd7, '0, 32'd9, 0);
        send_req(FN_FROM_US, '0, '0, '1, 0);
        send_req(FN_FROM_MS, '0, '0, '1, 0);
        send_req(FN_FROM_S, '0, '0, '1, 0);
        send_req(FN_TO_US, '1, '0, 32'd0, 0);
        send_req(FN_TO_US, 64'd4294967295999, '0, 32'd0, 0);
        send_req(FN_TO_US, 64'd4294967296000, '0, 32'd0, 0);
        send_req(FN_TO_MS, 64'd999999, '0, 32'd0, 0);
        send_req(FN_TO_S, '1, '0, 32'd0, 0);
        send_req(4'd12, '1, '1, '1, 0);
        send_req(4'd15, '1, '1, '1, 0);

        // random part, with one full drain partway through
        for (int i = 0; i < 900; i++) begin
            if (i == 450) begin
                s_valid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
            a = rand64();
            if ($urandom_range(0, 3) == 0)
                a = 64'($urandom_range(0, 5000)) * 64'd1000000000 - 64'($urandom_range(0, 1));
            send_req(($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 11)),
                     a, rand64(), rand32(), ($urandom_range(0, 9) != 0));
        end
        s_valid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (Latency + 20) @(posedge i_clk);
        $display("covered %0d requests over all function codes incl. unused ones,", n_req);
        $display("with random sender gaps, receiver stalls and one full drain");
        if (fail_cnt == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
